@@ design/fptda_pkg.sv @@
`default_nettype none
package fptda_pkg;
	localparam int VALUE_W = 48;
	localparam int CHAR_W = 7;
	localparam int PREC_W = 4;
	localparam int DIGIT_W = 4;

	localparam logic [PREC_W-1:0] PREC_RESET = 4'd2;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CHAR_POINT = 7'h2E;

	// transaction queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		digit_char = CHAR_ZERO + CHAR_W'(d);
	endfunction
endpackage
`default_nettype wire

@@ design/fptda_front.sv @@
`default_nettype none
module fptda_front #(
	parameter int FRAC_BITS = 16,
	parameter int INT_BITS = 32,
	parameter int MAX_PRECISION = 9,
	parameter int ITEM_W = 1 + INT_BITS + FRAC_BITS + fptda_pkg::PREC_W
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [fptda_pkg::VALUE_W-1:0] value,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [fptda_pkg::PREC_W-1:0]       cfg_data,
	output logic                                    push_valid,
	input  wire logic                               push_ready,
	output logic [ITEM_W-1:0]                       push_item
);
	import fptda_pkg::*;

	logic                 neg;
	logic [VALUE_W-1:0]   raw;
	logic [VALUE_W-1:0]   mag;
	logic [63:0]          ip_ext;
	logic                 ip_sat;
	logic [INT_BITS-1:0]  ipart;
	logic [PREC_W-1:0]    prec_sat;
	logic [PREC_W-1:0]    prec_q;
	logic                 valid_s1;
	logic [ITEM_W-1:0]    item_s1;

	assign raw = value;
	assign neg = raw[VALUE_W-1];
	assign mag = neg ? (~raw + VALUE_W'(1)) : raw;
	assign ip_ext = 64'(mag >> FRAC_BITS);
	// clamp integer part to what the back end can convert
	assign ip_sat = (ip_ext >> INT_BITS) != 64'd0;
	assign ipart = ip_sat ? {INT_BITS{1'b1}} : ip_ext[INT_BITS-1:0];
	assign prec_sat = (prec_q > PREC_W'(MAX_PRECISION)) ? PREC_W'(MAX_PRECISION) : prec_q;

	assign cfg_ready = 1'b1;
	assign in_ready = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prec_q <= PREC_RESET;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				prec_q <= cfg_data;
			end
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (push_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= {neg, ipart, mag[FRAC_BITS-1:0], prec_sat};
		end
	end
endmodule
`default_nettype wire

@@ design/fptda_queue.sv @@
`default_nettype none
module fptda_queue #(
	parameter int WIDTH = 53
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);
	import fptda_pkg::*;

	logic [WIDTH-1:0]  entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != QCNT_W'(QDEPTH);
	assign pop_valid = count_q != QCNT_W'(0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end
endmodule
`default_nettype wire

@@ design/fptda_back.sv @@
`default_nettype none
module fptda_back #(
	parameter int FRAC_BITS = 16,
	parameter int INT_BITS = 32,
	parameter int ITEM_W = 1 + INT_BITS + FRAC_BITS + fptda_pkg::PREC_W
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          pop_valid,
	output logic                               pop_ready,
	input  wire logic [ITEM_W-1:0]             pop_item,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [fptda_pkg::CHAR_W-1:0]       char_out,
	output logic                               last
);
	import fptda_pkg::*;

	localparam int NDIG = (INT_BITS * 30103) / 100000 + 1;
	localparam int BCD_W = NDIG * DIGIT_W;
	localparam int BIN_W = INT_BITS + (INT_BITS % 2);
	localparam int ITER = BIN_W / 2;
	localparam int ITER_W = $clog2(ITER + 1);
	localparam int IDX_W = $clog2(NDIG);
	localparam int PROD_W = FRAC_BITS + DIGIT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_LEAD,
		S_SIGN,
		S_INT,
		S_POINT,
		S_FRAC
	} state_t;

	state_t              state_q;
	logic                out_valid_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;
	logic [ITER_W-1:0]   iter_q;
	logic [IDX_W-1:0]    dig_idx_q;
	logic [PREC_W-1:0]   rem_q;

	logic                neg_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [BIN_W-1:0]    bin_q;
	logic [BCD_W-1:0]    bcd_q;

	logic [BCD_W-1:0]    bcd_next;
	logic [IDX_W-1:0]    top_idx;
	logic [DIGIT_W-1:0]  cur_dig;
	logic [PROD_W-1:0]   prod;
	logic [DIGIT_W-1:0]  frac_dig;
	logic                emit;
	logic [CHAR_W-1:0]   emit_char;
	logic                emit_last;
	logic                out_free;
	logic                fire;
	logic                load;

	assign pop_ready = state_q == S_IDLE;
	assign load = pop_valid && pop_ready;
	assign out_valid = out_valid_q;
	assign char_out = char_q;
	assign last = last_q;

	// two shift-and-add-three steps per cycle
	always_comb begin
		logic [BCD_W-1:0] bcd_t;
		bcd_t = bcd_q;
		for (int s = 0; s < 2; s++) begin
			for (int i = 0; i < NDIG; i++) begin
				if (bcd_t[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
					bcd_t[i*DIGIT_W +: DIGIT_W] = bcd_t[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
				end
			end
			bcd_t = {bcd_t[BCD_W-2:0], bin_q[BIN_W-1-s]};
		end
		bcd_next = bcd_t;
	end

	// highest non-zero digit, or the units digit when all are zero
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] != DIGIT_W'(0)) begin
				top_idx = IDX_W'(i);
			end
		end
	end

	assign cur_dig = bcd_q[dig_idx_q*DIGIT_W +: DIGIT_W];
	assign prod = (PROD_W'(frac_q) << 3) + (PROD_W'(frac_q) << 1);
	assign frac_dig = prod[FRAC_BITS +: DIGIT_W];

	always_comb begin
		emit = 1'b0;
		emit_char = CHAR_ZERO;
		emit_last = 1'b0;
		unique case (state_q)
			S_SIGN: begin
				emit = 1'b1;
				emit_char = CHAR_MINUS;
			end
			S_INT: begin
				emit = 1'b1;
				emit_char = digit_char(cur_dig);
			end
			S_POINT: begin
				emit = 1'b1;
				emit_char = CHAR_POINT;
				emit_last = rem_q == PREC_W'(0);
			end
			S_FRAC: begin
				emit = 1'b1;
				emit_char = digit_char(frac_dig);
				emit_last = rem_q == PREC_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign out_free = !out_valid_q || out_ready;
	assign fire = emit && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			char_q <= CHAR_ZERO;
			last_q <= 1'b0;
			iter_q <= '0;
			dig_idx_q <= '0;
			rem_q <= '0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				char_q <= emit_char;
				last_q <= emit_last;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						state_q <= S_CONV;
						iter_q <= '0;
						rem_q <= pop_item[PREC_W-1:0];
					end
				end
				S_CONV: begin
					iter_q <= iter_q + ITER_W'(1);
					if (iter_q == ITER_W'(ITER - 1)) begin
						state_q <= S_LEAD;
					end
				end
				S_LEAD: begin
					dig_idx_q <= top_idx;
					state_q <= neg_q ? S_SIGN : S_INT;
				end
				S_SIGN: begin
					if (fire) begin
						state_q <= S_INT;
					end
				end
				S_INT: begin
					if (fire) begin
						if (dig_idx_q == IDX_W'(0)) begin
							state_q <= S_POINT;
						end else begin
							dig_idx_q <= dig_idx_q - IDX_W'(1);
						end
					end
				end
				S_POINT: begin
					if (fire) begin
						state_q <= (rem_q == PREC_W'(0)) ? S_IDLE : S_FRAC;
					end
				end
				S_FRAC: begin
					if (fire) begin
						rem_q <= rem_q - PREC_W'(1);
						if (rem_q == PREC_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			neg_q <= pop_item[ITEM_W-1];
			bin_q <= BIN_W'(pop_item[ITEM_W-2 -: INT_BITS]);
			frac_q <= pop_item[PREC_W +: FRAC_BITS];
			bcd_q <= '0;
		end else if (state_q == S_CONV) begin
			bin_q <= bin_q << 2;
			bcd_q <= bcd_next;
		end else if (state_q == S_FRAC && fire) begin
			frac_q <= prod[FRAC_BITS-1:0];
		end
	end

	a_frac_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FRAC |-> rem_q != PREC_W'(0))
		else $error("fraction state entered with no digits left");

	a_int_digit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INT |-> cur_dig <= DIGIT_W'(9))
		else $error("integer digit out of decimal range");

	a_frac_digit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FRAC |-> frac_dig <= DIGIT_W'(9))
		else $error("fraction digit out of decimal range");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit_last |=> state_q == S_IDLE)
		else $error("final character sent but number not finished");
endmodule
`default_nettype wire

@@ design/fixed_point_to_decimal_ascii.sv @@
`default_nettype none
// Fixed-point to decimal text. Each transaction on the input carries one signed
// value with FRAC_BITS fraction bits; the block answers with its decimal text,
// one ASCII character per output transaction and last high on the final one:
// an optional '-', the integer digits without leading zeros, '.', and then
// 'precision' truncated fraction digits (clamped to MAX_PRECISION). Each number
// is loaded, put through the binary-to-BCD conversion, which runs two bits a
// cycle, and its leading digit is found; then one character goes out a cycle
// while the sink keeps ready high. A two-entry queue sits between input and
// converter, so up to three numbers can be taken in while one is being
// printed. precision resets to 2 and should be written only while no number
// is in flight.
module fixed_point_to_decimal_ascii #(
	parameter int FRAC_BITS = 16,
	parameter int INT_BITS = 32,
	parameter int MAX_PRECISION = 9
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [fptda_pkg::VALUE_W-1:0] value,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [fptda_pkg::CHAR_W-1:0]              char_out,
	output logic                                      last,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [fptda_pkg::PREC_W-1:0]         precision
);
	import fptda_pkg::*;

	localparam int ITEM_W = 1 + INT_BITS + FRAC_BITS + PREC_W;

	logic              push_valid;
	logic              push_ready;
	logic [ITEM_W-1:0] push_item;
	logic              pop_valid;
	logic              pop_ready;
	logic [ITEM_W-1:0] pop_item;

	fptda_front #(
		.FRAC_BITS(FRAC_BITS),
		.INT_BITS(INT_BITS),
		.MAX_PRECISION(MAX_PRECISION),
		.ITEM_W(ITEM_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(precision),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item(push_item)
	);

	fptda_queue #(
		.WIDTH(ITEM_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_item),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_item)
	);

	fptda_back #(
		.FRAC_BITS(FRAC_BITS),
		.INT_BITS(INT_BITS),
		.ITEM_W(ITEM_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item(pop_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_out(char_out),
		.last(last)
	);
endmodule
`default_nettype wire

@@ tb/sv/fptda_checker.sv @@
`timescale 1ns / 1ps
module fptda_checker #(
	parameter int FRAC_BITS = 16,
	parameter int INT_BITS = 32,
	parameter int MAX_PRECISION = 9
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	input  wire logic                                 in_ready,
	input  wire logic [fptda_pkg::VALUE_W-1:0]        value,
	input  wire logic                                 out_valid,
	input  wire logic                                 out_ready,
	input  wire logic [fptda_pkg::CHAR_W-1:0]         char_out,
	input  wire logic                                 last,
	input  wire logic                                 cfg_valid,
	input  wire logic                                 cfg_ready,
	input  wire logic [fptda_pkg::PREC_W-1:0]         precision,
	output int                                        chars_pending,
	output int                                        fail_count
);
	import fptda_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              fin;
	} glyph_t;

	glyph_t            text_q[$];
	logic [PREC_W-1:0] places_reg = PREC_RESET;
	int                pending_r = 0;
	int                error_total = 0;

	assign chars_pending = pending_r;
	assign fail_count = error_total;

	task automatic report_error(input string what);
		error_total++;
		if (error_total <= 100)
			$display("ERROR %0t ns: %s", $realtime, what);
	endtask

	// Append the expected text of one number to the queue
	function automatic void spell_number(input logic [VALUE_W-1:0] raw,
			input logic [PREC_W-1:0] places_cfg);
		logic              neg;
		logic [VALUE_W-1:0] mag;
		logic [63:0]       whole;
		logic [63:0]       frac;
		logic [63:0]       frac_mask;
		logic [63:0]       whole_max;
		logic [3:0]        digits[$];
		glyph_t            line[$];
		glyph_t            g;
		int                places;
		neg = raw[VALUE_W-1];
		mag = neg ? -raw : raw;
		frac_mask = (64'd1 << FRAC_BITS) - 64'd1;
		whole_max = (64'd1 << INT_BITS) - 64'd1;
		whole = 64'(mag) >> FRAC_BITS;
		frac = 64'(mag) & frac_mask;
		places = (places_cfg > MAX_PRECISION) ? MAX_PRECISION : int'(places_cfg);
		if (whole > whole_max)
			whole = whole_max;
		do begin
			digits.push_front(4'(whole % 64'd10));
			whole = whole / 64'd10;
		end while (whole != 64'd0);
		g.fin = 1'b0;
		if (neg) begin
			g.ch = CHAR_MINUS;
			line.push_back(g);
		end
		foreach (digits[i]) begin
			g.ch = CHAR_ZERO + CHAR_W'(digits[i]);
			line.push_back(g);
		end
		g.ch = CHAR_POINT;
		line.push_back(g);
		for (int k = 0; k < places; k++) begin
			frac = frac * 64'd10;
			g.ch = CHAR_ZERO + CHAR_W'(frac >> FRAC_BITS);
			frac = frac & frac_mask;
			line.push_back(g);
		end
		line[line.size()-1].fin = 1'b1;
		foreach (line[i])
			text_q.push_back(line[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		glyph_t want;
		if (!arst_n) begin
			places_reg = PREC_RESET;
			text_q.delete();
			pending_r <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (text_q.size() == 0) begin
					report_error($sformatf("character 0x%0h with nothing expected", char_out));
				end else begin
					want = text_q.pop_front();
					if (char_out !== want.ch)
						report_error($sformatf("char_out 0x%0h, expected 0x%0h",
							char_out, want.ch));
					if (last !== want.fin)
						report_error($sformatf("last %b on char 0x%0h, expected %b",
							last, want.ch, want.fin));
				end
			end
			if (cfg_valid && cfg_ready)
				places_reg = precision;
			if (in_valid && in_ready)
				spell_number(value, places_reg);
			pending_r <= text_q.size();
		end
	end
endmodule

@@ tb/sv/tb_fixed_point_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
module tb_fixed_point_to_decimal_ascii;
	import fptda_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam int INT_BITS = 32;
	localparam int MAX_PRECISION = 9;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [VALUE_W-1:0] value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [CHAR_W-1:0]  char_out;
	logic               last;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [PREC_W-1:0]  precision = '0;

	int chars_pending;
	int fail_count;
	int send_gap_pct = 0;
	int sink_stall_pct = 0;
	int stall_left = 0;

	always #4 clk = ~clk;

	fixed_point_to_decimal_ascii #(
		.FRAC_BITS(FRAC_BITS),
		.INT_BITS(INT_BITS),
		.MAX_PRECISION(MAX_PRECISION)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_out(char_out),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.precision(precision)
	);

	fptda_checker #(
		.FRAC_BITS(FRAC_BITS),
		.INT_BITS(INT_BITS),
		.MAX_PRECISION(MAX_PRECISION)
	) i_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_out(char_out),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.precision(precision),
		.chars_pending(chars_pending),
		.fail_count(fail_count)
	);

	// Sink: at random, ready drops for a burst when sink_stall_pct is non-zero
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= (stall_left == 1);
		end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
			stall_left <= $urandom_range(1, 11);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		#5_000_000;
		$display("fixed_point_to_decimal_ascii: mismatch");
		$finish;
	end

	task automatic send_number(input logic [VALUE_W-1:0] v);
		if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_precision(input logic [PREC_W-1:0] p);
		cfg_valid <= 1'b1;
		precision <= p;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Hold the sender until every expected character has come out
	task automatic drain_text();
		in_valid <= 1'b0;
		@(posedge clk);
		while (chars_pending != 0) @(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] make_fixed(input logic neg,
			input logic [31:0] whole, input logic [FRAC_BITS-1:0] frac);
		logic [VALUE_W-1:0] mag;
		mag = VALUE_W'({whole[VALUE_W-FRAC_BITS-2:0], frac});
		return neg ? -mag : mag;
	endfunction

	function automatic logic [VALUE_W-1:0] random_number();
		logic [63:0] wide;
		logic [31:0] pow;
		logic [31:0] whole;
		logic        neg;
		wide = {$urandom, $urandom};
		neg = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 4))
			0: return wide[VALUE_W-1:0];
			1: return make_fixed(neg, $urandom_range(0, 999), wide[FRAC_BITS-1:0]);
			2: return make_fixed(neg, 32'd0, wide[FRAC_BITS-1:0]);
			3: begin
				// land on either side of a power of ten
				pow = 32'd1;
				repeat ($urandom_range(0, 9)) pow = pow * 32'd10;
				whole = pow - 32'($urandom_range(0, 1));
				return make_fixed(neg, whole, wide[FRAC_BITS-1:0]);
			end
			default: begin
				case ($urandom_range(0, 3))
					0: wide[FRAC_BITS-1:0] = '0;
					1: wide[FRAC_BITS-1:0] = '1;
					2: wide[FRAC_BITS-1:0] = FRAC_BITS'(1) << (FRAC_BITS - 1);
					default: wide[FRAC_BITS-1:0] = FRAC_BITS'(1);
				endcase
				return make_fixed(neg, $urandom_range(0, 99), wide[FRAC_BITS-1:0]);
			end
		endcase
	endfunction

	initial begin
		logic [VALUE_W-1:0] corner[12];
		logic [PREC_W-1:0]  phase_prec[8];
		corner = '{
			48'h0000_0000_0000,
			48'h7FFF_FFFF_FFFF,
			48'h8000_0000_0000,
			48'hFFFF_FFFF_FFFF,
			48'h0000_0000_0001,
			48'h0000_0000_FFFF,
			48'h0000_0000_8000,
			48'hFFFF_FFFF_8000,
			48'h0000_0001_0000,
			48'h0000_000A_0000,
			48'h0000_270F_FFFF,
			48'h3B9A_CA00_0000
		};
		phase_prec = '{4'd0, 4'd15, 4'd10, 4'd5,
			4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 4'd9, 4'd3};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 25;
		sink_stall_pct = 20;
		// corner values at the reset precision, then at the widest precision
		foreach (corner[i])
			send_number(corner[i]);
		drain_text();
		write_precision(4'(MAX_PRECISION));
		foreach (corner[i])
			send_number(corner[i]);
		drain_text();

		foreach (phase_prec[p]) begin
			if (p == 7) begin
				send_gap_pct = 0;
				sink_stall_pct = 0;
			end else begin
				send_gap_pct = $urandom_range(0, 40);
				sink_stall_pct = $urandom_range(0, 40);
			end
			write_precision(phase_prec[p]);
			repeat (50)
				send_number(random_number());
			drain_text();
		end

		repeat (30) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("fixed_point_to_decimal_ascii: match");
		else
			$display("fixed_point_to_decimal_ascii: mismatch");
		$finish;
	end
endmodule

@@ files.f @@
design/fptda_pkg.sv
design/fptda_front.sv
design/fptda_queue.sv
design/fptda_back.sv
design/fixed_point_to_decimal_ascii.sv
tb/sv/fptda_checker.sv
tb/sv/tb_fixed_point_to_decimal_ascii.sv
